[hw/rtl/pfe_pkg.sv]
// ---------------------------------------------------------------------------
// pfe_pkg
// Shared constants, codes and control structs of the page framebuffer engine.
// ---------------------------------------------------------------------------
package pfe_pkg;

    localparam int FRAME_WIDTH  = 128;
    localparam int FRAME_HEIGHT = 64;
    localparam int CHUNK_BYTES  = 16;

    localparam int PAGE_COUNT   = (FRAME_HEIGHT + 7) / 8;
    localparam int STORE_BYTES  = FRAME_WIDTH * PAGE_COUNT;
    localparam int ADDR_W       = $clog2(STORE_BYTES);
    localparam int IDX_W        = ADDR_W + 1;
    localparam int COL_W        = 7;
    localparam int PAGE_W       = 3;
    localparam int ROW_W        = 6;
    localparam int CHUNK_W      = CHUNK_BYTES * 8;
    localparam int CHUNK_CNT_W  = $clog2(CHUNK_BYTES);

    typedef enum logic [1:0] {
        OP_PIXEL  = 2'd0,
        OP_ROW    = 2'd1,
        OP_FILL   = 2'd2,
        OP_UPDATE = 2'd3
    } pfe_op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_OOB   = 2'd1,
        ST_CHUNK = 2'd2
    } pfe_status_t;

    typedef struct packed {
        pfe_op_t            opcode;
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic               pixel_on;
        logic [ROW_W-1:0]   frame_row;
        logic [3:0]         byte_column;
        logic [7:0]         data_byte;
        logic [COL_W-1:0]   col_start;
        logic [COL_W-1:0]   col_end;
        logic [PAGE_W-1:0]  page_start;
        logic [PAGE_W-1:0]  page_end;
    } pfe_item_t;

    typedef struct packed {
        pfe_status_t        status;
        logic [PAGE_W-1:0]  chunk_page;
        logic [COL_W-1:0]   chunk_column;
        logic [63:0]        chunk_low;
        logic [63:0]        chunk_high;
        logic               first_of_run;
        logic               last_of_run;
        logic [COL_W-1:0]   echo_col_start;
        logic [COL_W-1:0]   echo_col_end;
        logic [PAGE_W-1:0]  echo_page_start;
        logic [PAGE_W-1:0]  echo_page_end;
    } pfe_result_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rmw_rd;
        logic rmw_wr;
        logic fill_en;
        logic fill_zero;
        logic upd_rd;
        logic out_single;
        logic out_chunk;
    } pfe_cmd_t;

    // datapath to controller
    typedef struct packed {
        pfe_op_t in_op;
        logic    in_empty;
        logic    rmw_last;
        logic    fill_last;
        logic    rd_last;
        logic    upd_done;
    } pfe_stat_t;

endpackage

[hw/rtl/pfe_if.sv]
// ---------------------------------------------------------------------------
// pfe_if
// Valid/ready channels of the page framebuffer engine: command and result.
// ---------------------------------------------------------------------------
interface pfe_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic               pixel_on;
    logic [5:0]         frame_row;
    logic [3:0]         byte_column;
    logic [7:0]         data_byte;
    logic [6:0]         col_start;
    logic [6:0]         col_end;
    logic [2:0]         page_start;
    logic [2:0]         page_end;

    modport source (
        output valid, opcode, pixel_x, pixel_y, pixel_on, frame_row, byte_column,
               data_byte, col_start, col_end, page_start, page_end,
        input  ready
    );
    modport sink (
        input  valid, opcode, pixel_x, pixel_y, pixel_on, frame_row, byte_column,
               data_byte, col_start, col_end, page_start, page_end,
        output ready
    );
endinterface

interface pfe_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [2:0]  chunk_page;
    logic [6:0]  chunk_column;
    logic [63:0] chunk_low;
    logic [63:0] chunk_high;
    logic        first_of_run;
    logic        last_of_run;
    logic [6:0]  echo_col_start;
    logic [6:0]  echo_col_end;
    logic [2:0]  echo_page_start;
    logic [2:0]  echo_page_end;

    modport source (
        output valid, status, chunk_page, chunk_column, chunk_low, chunk_high,
               first_of_run, last_of_run, echo_col_start, echo_col_end,
               echo_page_start, echo_page_end,
        input  ready
    );
    modport sink (
        input  valid, status, chunk_page, chunk_column, chunk_low, chunk_high,
               first_of_run, last_of_run, echo_col_start, echo_col_end,
               echo_page_start, echo_page_end,
        output ready
    );
endinterface

[hw/rtl/pfe_datapath.sv]
// ---------------------------------------------------------------------------
// pfe_datapath
// Frame store memory, read-modify-write, fill sweep, chunk assembly and the
// result register.
// ---------------------------------------------------------------------------
module pfe_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pfe_pkg::pfe_item_t   item,
    input  pfe_pkg::pfe_cmd_t    ctl,
    output pfe_pkg::pfe_stat_t   stat,
    output pfe_pkg::pfe_result_t result
);
    import pfe_pkg::*;

    logic [7:0]             mem [STORE_BYTES];
    logic [7:0]             rd_data_reg;

    pfe_op_t                op_reg;
    logic [COL_W-1:0]       base_col_reg;
    logic [ROW_W-1:0]       row_reg;
    logic                   on_reg;
    logic [7:0]             data_reg;
    logic                   pix_ok_reg;
    logic                   ok_reg;
    logic [2:0]             step_reg;
    logic [ADDR_W-1:0]      fill_addr_reg;

    logic [COL_W-1:0]       cs_reg;
    logic [COL_W-1:0]       ce_reg;
    logic [PAGE_W-1:0]      ps_reg;
    logic [PAGE_W-1:0]      pe_reg;
    logic [COL_W:0]         col_reg;
    logic [PAGE_W-1:0]      page_reg;
    logic [CHUNK_CNT_W-1:0] k_reg;
    logic                   rd_valid_reg;
    logic                   rd_zero_reg;
    logic [CHUNK_W-1:0]     chunk_reg;
    logic                   first_reg;
    pfe_result_t            result_reg;

    logic                   row_mode;
    logic [COL_W:0]         rmw_col;
    logic                   step_ok;
    logic [ADDR_W-1:0]      rmw_addr;
    logic                   rmw_on;
    logic [7:0]             mask;
    logic [7:0]             rmw_byte;
    logic [IDX_W-1:0]       upd_idx;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [7:0]             wr_data;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic [COL_W:0]         col_next;
    logic                   col_wrap;
    logic                   upd_done;
    logic                   pix_in;
    pfe_result_t            single_res;
    pfe_result_t            chunk_res;

    // pixel lands in the frame: sign clear and below the frame size
    assign pix_in = !item.pixel_x[15] && !item.pixel_y[15]
                    && ($unsigned(item.pixel_x) < 16'(FRAME_WIDTH))
                    && ($unsigned(item.pixel_y) < 16'(FRAME_HEIGHT));

    assign row_mode = (op_reg == OP_ROW);
    assign rmw_col  = (COL_W+1)'(base_col_reg) + (COL_W+1)'(step_reg);
    assign step_ok  = row_mode
                      ? ((rmw_col < (COL_W+1)'(FRAME_WIDTH))
                         && ({1'b0, row_reg} < (ROW_W+1)'(FRAME_HEIGHT)))
                      : pix_ok_reg;
    assign rmw_addr = ADDR_W'(rmw_col[COL_W-1:0])
                      + ADDR_W'(row_reg[ROW_W-1:3]) * ADDR_W'(FRAME_WIDTH);
    // row byte is MSB leftmost: step i takes bit 7-i
    assign rmw_on   = row_mode ? data_reg[~step_reg] : on_reg;
    assign mask     = 8'(1) << row_reg[2:0];
    assign rmw_byte = rmw_on ? (rd_data_reg | mask) : (rd_data_reg & ~mask);

    assign upd_idx  = IDX_W'(col_reg) + IDX_W'(page_reg) * IDX_W'(FRAME_WIDTH)
                      + IDX_W'(k_reg);

    assign wr_en    = ctl.fill_en || (ctl.rmw_wr && step_ok);
    assign wr_addr  = ctl.fill_en ? fill_addr_reg : rmw_addr;
    assign wr_data  = ctl.fill_en ? (ctl.fill_zero ? 8'h00 : data_reg) : rmw_byte;
    assign rd_en    = ctl.rmw_rd || ctl.upd_rd;
    assign rd_addr  = ctl.rmw_rd ? rmw_addr : upd_idx[ADDR_W-1:0];

    assign col_next = col_reg + (COL_W+1)'(CHUNK_BYTES);
    assign col_wrap = col_next > {1'b0, ce_reg};
    assign upd_done = col_wrap && (page_reg == pe_reg);

    assign stat.in_op     = item.opcode;
    assign stat.in_empty  = (item.page_start > item.page_end)
                            || (item.col_start > item.col_end);
    assign stat.rmw_last  = !row_mode || (step_reg == 3'd7);
    assign stat.fill_last = (fill_addr_reg == ADDR_W'(STORE_BYTES - 1));
    assign stat.rd_last   = (k_reg == CHUNK_CNT_W'(CHUNK_BYTES - 1));
    assign stat.upd_done  = upd_done;

    assign result = result_reg;

    always_comb
    begin
        single_res             = '0;
        single_res.status      = ((op_reg inside {OP_PIXEL, OP_ROW}) && !ok_reg)
                                 ? ST_OOB : ST_DONE;
        single_res.last_of_run = 1'b1;
        if (op_reg == OP_UPDATE)
        begin
            single_res.echo_col_start  = cs_reg;
            single_res.echo_col_end    = ce_reg;
            single_res.echo_page_start = ps_reg;
            single_res.echo_page_end   = pe_reg;
        end

        chunk_res.status          = ST_CHUNK;
        chunk_res.chunk_page      = page_reg;
        chunk_res.chunk_column    = col_reg[COL_W-1:0];
        chunk_res.chunk_low       = chunk_reg[63:0];
        chunk_res.chunk_high      = chunk_reg[CHUNK_W-1:64];
        chunk_res.first_of_run    = first_reg;
        chunk_res.last_of_run     = upd_done;
        chunk_res.echo_col_start  = cs_reg;
        chunk_res.echo_col_end    = ce_reg;
        chunk_res.echo_page_start = ps_reg;
        chunk_res.echo_page_end   = pe_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            fill_addr_reg <= '0;
            k_reg         <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= ctl.upd_rd;
            if (ctl.load)
            begin
                step_reg <= '0;
                k_reg    <= '0;
            end
            else
            begin
                if (ctl.rmw_wr)
                begin
                    step_reg <= step_reg + 3'd1;
                end
                if (ctl.upd_rd)
                begin
                    k_reg <= k_reg + CHUNK_CNT_W'(1);
                end
            end
            if (ctl.fill_en)
            begin
                fill_addr_reg <= stat.fill_last ? '0 : fill_addr_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg       <= item.opcode;
            base_col_reg <= (item.opcode == OP_ROW) ? {item.byte_column, 3'b000}
                                                    : item.pixel_x[COL_W-1:0];
            row_reg      <= (item.opcode == OP_ROW) ? item.frame_row
                                                    : item.pixel_y[ROW_W-1:0];
            on_reg       <= item.pixel_on;
            data_reg     <= item.data_byte;
            pix_ok_reg   <= pix_in;
            ok_reg       <= 1'b1;
            cs_reg       <= item.col_start;
            ce_reg       <= item.col_end;
            ps_reg       <= item.page_start;
            pe_reg       <= item.page_end;
            col_reg      <= {1'b0, item.col_start};
            page_reg     <= item.page_start;
            first_reg    <= 1'b1;
        end
        else
        begin
            if (ctl.rmw_wr && !step_ok)
            begin
                ok_reg <= 1'b0;
            end
            if (ctl.out_chunk)
            begin
                first_reg <= 1'b0;
                if (col_wrap)
                begin
                    col_reg  <= {1'b0, cs_reg};
                    page_reg <= page_reg + PAGE_W'(1);
                end
                else
                begin
                    col_reg <= col_next;
                end
            end
        end

        rd_zero_reg <= (upd_idx >= IDX_W'(STORE_BYTES));
        // shift each byte in at the top; byte 0 ends in the low bits
        if (rd_valid_reg)
        begin
            chunk_reg <= {(rd_zero_reg ? 8'h00 : rd_data_reg), chunk_reg[CHUNK_W-1:8]};
        end

        if (ctl.out_single)
        begin
            result_reg <= single_res;
        end
        else if (ctl.out_chunk)
        begin
            result_reg <= chunk_res;
        end
    end

endmodule

[hw/rtl/pfe_ctrl.sv]
// ---------------------------------------------------------------------------
// pfe_ctrl
// Sequencer of the page framebuffer engine: clear pass, operation steps and
// the result valid flag.
// ---------------------------------------------------------------------------
module pfe_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    output logic               res_valid,
    input  logic               res_ready,
    input  pfe_pkg::pfe_stat_t stat,
    output pfe_pkg::pfe_cmd_t  ctl
);
    import pfe_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR    = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_RMW_RD   = 9'b000000100,
        S_RMW_WR   = 9'b000001000,
        S_FILL     = 9'b000010000,
        S_UPD_RD   = 9'b000100000,
        S_UPD_LAST = 9'b001000000,
        S_UPD_OUT  = 9'b010000000,
        S_RESP     = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   res_valid_reg;
    logic   res_valid_next;
    logic   out_free;

    assign out_free   = !res_valid_reg || res_ready;
    assign item_ready = (state_reg == S_IDLE);
    assign res_valid  = res_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg && !res_ready;
        ctl            = '0;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.fill_en   = 1'b1;
                ctl.fill_zero = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    ctl.load = 1'b1;
                    case (stat.in_op)
                        OP_PIXEL, OP_ROW: state_next = S_RMW_RD;
                        OP_FILL:          state_next = S_FILL;
                        OP_UPDATE:        state_next = stat.in_empty ? S_RESP : S_UPD_RD;
                        default:          state_next = S_RESP;
                    endcase
                end
            end
            S_RMW_RD:
            begin
                ctl.rmw_rd = 1'b1;
                state_next = S_RMW_WR;
            end
            S_RMW_WR:
            begin
                ctl.rmw_wr = 1'b1;
                state_next = stat.rmw_last ? S_RESP : S_RMW_RD;
            end
            S_FILL:
            begin
                ctl.fill_en = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_UPD_RD:
            begin
                ctl.upd_rd = 1'b1;
                if (stat.rd_last)
                begin
                    state_next = S_UPD_LAST;
                end
            end
            S_UPD_LAST:
            begin
                // last byte of the chunk lands this cycle
                state_next = S_UPD_OUT;
            end
            S_UPD_OUT:
            begin
                if (out_free)
                begin
                    ctl.out_chunk  = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = stat.upd_done ? S_IDLE : S_UPD_RD;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    ctl.out_single = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

[hw/rtl/page_framebuffer_engine.sv]
// ---------------------------------------------------------------------------
// page_framebuffer_engine
// 128x64 one-bit framebuffer in page layout: pixel and row-byte drawing,
// pattern fill and chunked read-out of a column/page range.
// ---------------------------------------------------------------------------
//  channel | dir | handshake      | item
//  --------+-----+----------------+---------------------------------------
//  cmd     | in  | valid / ready  | opcode with draw, fill or range fields
//  res     | out | valid / ready  | status, 16-byte chunk, marks, echo
//
//  One item at a time, through a single-port 1024x8 store with a registered
//  read. Draw pixel does one read-modify-write pair, draw row byte eight
//  such pairs, fill writes one byte a cycle and update reads chunks bytewise.
//  After reset a clear pass zeroes the store; cmd.ready stays low meanwhile.
//  A waiting result holds in the output register; the next item is accepted
//  and its work stalls only when it needs that register.
// ---------------------------------------------------------------------------
module page_framebuffer_engine (
    input  logic   clk,
    input  logic   rst_n,
    pfe_item_if.sink     cmd,
    pfe_result_if.source res
);
    import pfe_pkg::*;

    pfe_item_t   item;
    pfe_result_t result;
    pfe_cmd_t    ctl;
    pfe_stat_t   stat;

    assign item.opcode      = pfe_op_t'(cmd.opcode);
    assign item.pixel_x     = cmd.pixel_x;
    assign item.pixel_y     = cmd.pixel_y;
    assign item.pixel_on    = cmd.pixel_on;
    assign item.frame_row   = cmd.frame_row;
    assign item.byte_column = cmd.byte_column;
    assign item.data_byte   = cmd.data_byte;
    assign item.col_start   = cmd.col_start;
    assign item.col_end     = cmd.col_end;
    assign item.page_start  = cmd.page_start;
    assign item.page_end    = cmd.page_end;

    assign res.status          = result.status;
    assign res.chunk_page      = result.chunk_page;
    assign res.chunk_column    = result.chunk_column;
    assign res.chunk_low       = result.chunk_low;
    assign res.chunk_high      = result.chunk_high;
    assign res.first_of_run    = result.first_of_run;
    assign res.last_of_run     = result.last_of_run;
    assign res.echo_col_start  = result.echo_col_start;
    assign res.echo_col_end    = result.echo_col_end;
    assign res.echo_page_start = result.echo_page_start;
    assign res.echo_page_end   = result.echo_page_end;

    pfe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (cmd.valid),
        .item_ready (cmd.ready),
        .res_valid  (res.valid),
        .res_ready  (res.ready),
        .stat       (stat),
        .ctl        (ctl)
    );

    pfe_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .ctl    (ctl),
        .stat   (stat),
        .result (result)
    );

endmodule
